// ===== design/sum8_checked_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sum8 checked frame receiver
// Shared concurrent-check shorthands, sampled on clock, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SUM8_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define SUM8_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// property that must hold at every edge
`define S8FR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define S8FR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/s8fr_pkg.sv =====
// ----------------------------------------------------------------------------
// s8fr_pkg
// Constants and types shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package s8fr_pkg;

   localparam int FRAME_BYTES = 34;
   localparam int HIST_BYTES  = FRAME_BYTES - 1;
   localparam int HELD_WIDTH  = $clog2(FRAME_BYTES + 1);
   localparam logic [HELD_WIDTH-1:0] HELD_MAX = HELD_WIDTH'(HIST_BYTES);

   // register map
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_BYTE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TYPE_BYTE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH_CODE = 2'd2;

   localparam logic [7:0] SYNC_BYTE_RESET   = 8'hAA;
   localparam logic [7:0] TYPE_BYTE_RESET   = 8'h01;
   localparam logic [7:0] LENGTH_CODE_RESET = 8'd30;

   // frame byte offsets
   localparam int POS_COUNT_LEFT   = 3;
   localparam int POS_COUNT_RIGHT  = 7;
   localparam int POS_PERIOD_LEFT  = 11;
   localparam int POS_PERIOD_RIGHT = 13;
   localparam int POS_RANGES_LOW   = 15;
   localparam int POS_RANGES_HIGH  = 21;
   localparam int POS_VOLTAGE      = 27;
   localparam int POS_CHARGE       = 29;
   localparam int POS_ANGLE        = 31;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_type;

   typedef struct packed {
      logic        [31:0] wheel_count_left;
      logic        [31:0] wheel_count_right;
      logic        [15:0] wheel_period_left;
      logic        [15:0] wheel_period_right;
      logic        [47:0] ranges_low;
      logic        [47:0] ranges_high;
      logic        [15:0] battery_voltage;
      logic        [15:0] battery_charge;
      logic        [15:0] heading_angle;
      logic signed [31:0] wheel_delta_left;
      logic signed [31:0] wheel_delta_right;
   } result_type;

endpackage

// ===== design/s8fr_req_if.sv =====
// ----------------------------------------------------------------------------
// s8fr_req_if
// Byte channel into the frame receiver.
// ----------------------------------------------------------------------------
interface s8fr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/s8fr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// s8fr_rsp_if
// Decoded frame channel out of the frame receiver.
// ----------------------------------------------------------------------------
interface s8fr_rsp_if;
   logic               valid;
   logic               ready;
   logic        [31:0] wheel_count_left;
   logic        [31:0] wheel_count_right;
   logic        [15:0] wheel_period_left;
   logic        [15:0] wheel_period_right;
   logic        [47:0] ranges_low;
   logic        [47:0] ranges_high;
   logic        [15:0] battery_voltage;
   logic        [15:0] battery_charge;
   logic        [15:0] heading_angle;
   logic signed [31:0] wheel_delta_left;
   logic signed [31:0] wheel_delta_right;

   modport source (
      output valid, input ready,
      output wheel_count_left, output wheel_count_right,
      output wheel_period_left, output wheel_period_right,
      output ranges_low, output ranges_high,
      output battery_voltage, output battery_charge, output heading_angle,
      output wheel_delta_left, output wheel_delta_right
   );
   modport sink (
      input valid, output ready,
      input wheel_count_left, input wheel_count_right,
      input wheel_period_left, input wheel_period_right,
      input ranges_low, input ranges_high,
      input battery_voltage, input battery_charge, input heading_angle,
      input wheel_delta_left, input wheel_delta_right
   );
endinterface

// ===== design/sum8_checked_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sum8_checked_frame_receiver
// Frame sync on a byte stream with header match and 8-bit sum check;
// unpacks good frames into sensor fields and wheel count deltas.
// ----------------------------------------------------------------------------
//   channel   direction  handshake          beat contents
//   req_bus   in         valid/ready        rx_byte, one link byte
//   rsp_bus   out        valid/ready        decoded frame fields and deltas
//   csr_*     in         csr_wr_en only     sync, type, length code registers
//
// One byte is taken every cycle while req_bus.ready is high; the result of a good frame
// is registered with its checksum byte and shows on rsp_bus from the result register.
// The check uses a running sum over the held bytes, so the work per byte is
// one compare set and one 8-bit add and subtract.
// Reset is synchronous; there is no clearing pass.
// A stalled rsp_bus parks one more result in the skid stage; req_bus.ready
// drops only while that stage is occupied.
// ----------------------------------------------------------------------------
module sum8_checked_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [s8fr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [s8fr_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data,
   s8fr_req_if.sink                             req_bus,
   s8fr_rsp_if.source                           rsp_bus
);
   import s8fr_pkg::*;

   logic            byte_valid;
   logic            frame_hit;
   logic            in_ready;
   frame_bytes_type frame;
   result_type      result;

   // input beat accept
   assign req_bus.ready = in_ready;
   assign byte_valid    = req_bus.valid && in_ready;

   s8fr_window u_window (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .byte_valid  (byte_valid),
      .rx_byte     (req_bus.rx_byte),
      .frame_hit   (frame_hit),
      .frame       (frame)
   );

   s8fr_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .frame_hit (frame_hit),
      .frame     (frame),
      .result    (result)
   );

   s8fr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_hit),
      .push_data (result),
      .in_ready  (in_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== design/s8fr_window.sv =====
// ----------------------------------------------------------------------------
// s8fr_window
// Byte history, fill count, running sum and header match; flags a good frame.
// ----------------------------------------------------------------------------
`include "sum8_checked_frame_receiver_defines.svh"

module s8fr_window (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [s8fr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [s8fr_pkg::CSR_DATA_WIDTH-1:0]    csr_wr_data,
   input  logic                                   byte_valid,
   input  logic [7:0]                             rx_byte,
   output logic                                   frame_hit,
   output s8fr_pkg::frame_bytes_type              frame
);
   import s8fr_pkg::*;

   logic [7:0]            sync_ff, type_ff, length_ff;
   logic [7:0]            hist_ff [HIST_BYTES];
   logic [HELD_WIDTH-1:0] held_ff, held_in;
   logic [7:0]            sum_ff, sum_in;
   logic                  full;
   logic                  frame_ok;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= SYNC_BYTE_RESET;
         type_ff   <= TYPE_BYTE_RESET;
         length_ff <= LENGTH_CODE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SYNC_BYTE:   sync_ff   <= csr_wr_data;
            CSR_TYPE_BYTE:   type_ff   <= csr_wr_data;
            CSR_LENGTH_CODE: length_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // candidate frame: held history followed by the incoming byte
   always_comb begin
      for (int k = 0; k < HIST_BYTES; k++) begin
         frame[k] = hist_ff[k];
      end
      frame[FRAME_BYTES-1] = rx_byte;
   end

   // history is full once it holds every byte before the checksum byte
   assign full     = (held_ff == HELD_MAX);
   assign frame_ok = (hist_ff[0] == sync_ff) && (hist_ff[1] == type_ff)
                   && (hist_ff[2] == length_ff) && (sum_ff == rx_byte);
   assign frame_hit = byte_valid && full && frame_ok;

   // fill count and running sum of the held bytes
   always_comb begin
      held_in = held_ff;
      sum_in  = sum_ff;
      if (byte_valid) begin
         if (frame_hit) begin
            held_in = '0;
            sum_in  = '0;
         end else if (full) begin
            sum_in = sum_ff + rx_byte - hist_ff[0];
         end else begin
            held_in = held_ff + 1'b1;
            sum_in  = sum_ff + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         sum_ff  <= '0;
      end else begin
         held_ff <= held_in;
         sum_ff  <= sum_in;
      end
   end

   // shift line, newest byte at the top
   always_ff @(posedge clock) begin
      if (byte_valid) begin
         for (int k = 0; k < HIST_BYTES - 1; k++) begin
            hist_ff[k] <= hist_ff[k+1];
         end
         hist_ff[HIST_BYTES-1] <= rx_byte;
      end
   end

   `S8FR_ASSERT(a_held_range, held_ff <= HELD_MAX, "fill count beyond history depth")
   `S8FR_ASSERT_NEXT(a_hit_empties, frame_hit, held_ff == '0 && sum_ff == '0,
                     "history not emptied after a good frame")
   `S8FR_ASSERT_NEXT(a_slide_keeps_full, byte_valid && full && !frame_ok, held_ff == HELD_MAX,
                     "history lost bytes on a rejected frame")

endmodule

// ===== design/s8fr_decode.sv =====
// ----------------------------------------------------------------------------
// s8fr_decode
// Field extraction from a good frame and wheel count delta tracking.
// ----------------------------------------------------------------------------
module s8fr_decode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      frame_hit,
   input  s8fr_pkg::frame_bytes_type frame,
   output s8fr_pkg::result_type      result
);
   import s8fr_pkg::*;

   logic [31:0] prev_left_ff, prev_right_ff;
   logic [31:0] delta_left_ff, delta_right_ff;
   logic [31:0] delta_left_in, delta_right_in;
   logic [31:0] count_left, count_right;
   logic        have_prev;

   assign count_left  = {frame[POS_COUNT_LEFT+3], frame[POS_COUNT_LEFT+2],
                         frame[POS_COUNT_LEFT+1], frame[POS_COUNT_LEFT]};
   assign count_right = {frame[POS_COUNT_RIGHT+3], frame[POS_COUNT_RIGHT+2],
                         frame[POS_COUNT_RIGHT+1], frame[POS_COUNT_RIGHT]};

   // deltas move only once some previous count is nonzero
   assign have_prev      = (prev_left_ff != '0) || (prev_right_ff != '0);
   assign delta_left_in  = have_prev ? (count_left - prev_left_ff) : delta_left_ff;
   assign delta_right_in = have_prev ? (prev_right_ff - count_right) : delta_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff   <= '0;
         prev_right_ff  <= '0;
         delta_left_ff  <= '0;
         delta_right_ff <= '0;
      end else if (frame_hit) begin
         prev_left_ff   <= count_left;
         prev_right_ff  <= count_right;
         delta_left_ff  <= delta_left_in;
         delta_right_ff <= delta_right_in;
      end
   end

   // little-endian field unpacking
   always_comb begin
      result.wheel_count_left   = count_left;
      result.wheel_count_right  = count_right;
      result.wheel_period_left  = {frame[POS_PERIOD_LEFT+1], frame[POS_PERIOD_LEFT]};
      result.wheel_period_right = {frame[POS_PERIOD_RIGHT+1], frame[POS_PERIOD_RIGHT]};
      result.ranges_low         = {frame[POS_RANGES_LOW+5], frame[POS_RANGES_LOW+4],
                                   frame[POS_RANGES_LOW+3], frame[POS_RANGES_LOW+2],
                                   frame[POS_RANGES_LOW+1], frame[POS_RANGES_LOW]};
      result.ranges_high        = {frame[POS_RANGES_HIGH+5], frame[POS_RANGES_HIGH+4],
                                   frame[POS_RANGES_HIGH+3], frame[POS_RANGES_HIGH+2],
                                   frame[POS_RANGES_HIGH+1], frame[POS_RANGES_HIGH]};
      result.battery_voltage    = {frame[POS_VOLTAGE+1], frame[POS_VOLTAGE]};
      result.battery_charge     = {frame[POS_CHARGE+1], frame[POS_CHARGE]};
      result.heading_angle      = {frame[POS_ANGLE+1], frame[POS_ANGLE]};
      result.wheel_delta_left   = $signed(delta_left_in);
      result.wheel_delta_right  = $signed(delta_right_in);
   end

endmodule

// ===== design/s8fr_out_buf.sv =====
// ----------------------------------------------------------------------------
// s8fr_out_buf
// Result register with a one-entry skid stage in front of the output channel.
// ----------------------------------------------------------------------------
`include "sum8_checked_frame_receiver_defines.svh"

module s8fr_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  s8fr_pkg::result_type push_data,
   output logic                 in_ready,
   s8fr_rsp_if.source           rsp_bus
);
   import s8fr_pkg::*;

   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;
   logic       pop;

   assign pop      = out_valid_ff && rsp_bus.ready;
   assign in_ready = !skid_valid_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            out_ff <= push_data;
         end
      end
   end

   // drive the channel
   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.wheel_count_left   = out_ff.wheel_count_left;
   assign rsp_bus.wheel_count_right  = out_ff.wheel_count_right;
   assign rsp_bus.wheel_period_left  = out_ff.wheel_period_left;
   assign rsp_bus.wheel_period_right = out_ff.wheel_period_right;
   assign rsp_bus.ranges_low         = out_ff.ranges_low;
   assign rsp_bus.ranges_high        = out_ff.ranges_high;
   assign rsp_bus.battery_voltage    = out_ff.battery_voltage;
   assign rsp_bus.battery_charge     = out_ff.battery_charge;
   assign rsp_bus.heading_angle      = out_ff.heading_angle;
   assign rsp_bus.wheel_delta_left   = out_ff.wheel_delta_left;
   assign rsp_bus.wheel_delta_right  = out_ff.wheel_delta_right;

   `S8FR_ASSERT(a_skid_behind_out, !skid_valid_ff || out_valid_ff,
                "skid entry held with an empty result register")
   `S8FR_ASSERT(a_no_push_when_full, !(push && skid_valid_ff),
                "result arrived while the skid stage was full")

endmodule

// ===== bench/sum8_checked_frame_receiver_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum8_checked_frame_receiver_test
// Feeds link bytes into the frame receiver: good frames, frames with one bad
// header byte or a bad sum, cut frames and noise. A byte-level copy of the
// sync window predicts every decoded frame, and each result beat is checked
// field by field. Header registers change between phases, both channels
// stall at random, and one stretch holds the result side off to back up input.
// ----------------------------------------------------------------------------
module sum8_checked_frame_receiver_test;
   import s8fr_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 5;
   localparam int MAX_GAP       = 17;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_BYTES   = 280;
   localparam int BURST_FRAMES  = 6;
   localparam int MAX_PRINTS    = 30;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   // byte-level frame sync predictor and queue of decoded frames
   class frame_tracker;
      logic [7:0]      sync_byte;
      logic [7:0]      type_byte;
      logic [7:0]      length_code;
      frame_bytes_type win;
      int              held;
      logic [31:0]     prev_left;
      logic [31:0]     prev_right;
      logic [31:0]     delta_left;
      logic [31:0]     delta_right;
      result_type      decoded_q[$];
      int              mismatches;
      int              frames_seen;
      int              delta_updates;

      function new();
         sync_byte     = SYNC_BYTE_RESET;
         type_byte     = TYPE_BYTE_RESET;
         length_code   = LENGTH_CODE_RESET;
         win           = '0;
         held          = 0;
         prev_left     = '0;
         prev_right    = '0;
         delta_left    = '0;
         delta_right   = '0;
         mismatches    = 0;
         frames_seen   = 0;
         delta_updates = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [7:0] value);
         case (index)
            CSR_SYNC_BYTE:   sync_byte = value;
            CSR_TYPE_BYTE:   type_byte = value;
            CSR_LENGTH_CODE: length_code = value;
            default: ;
         endcase
      endfunction

      function logic [31:0] le32(int pos);
         return {win[pos+3], win[pos+2], win[pos+1], win[pos]};
      endfunction

      function logic [15:0] le16(int pos);
         return {win[pos+1], win[pos]};
      endfunction

      // slide one link byte through the window
      function void take_byte(logic [7:0] b);
         logic [7:0] sum;
         result_type r;
         int         i;
         if (held >= FRAME_BYTES) held = HIST_BYTES;
         win[held] = b;
         held++;
         if (held < FRAME_BYTES) return;
         sum = '0;
         for (i = 0; i < HIST_BYTES; i++) sum += win[i];
         // any header or sum mismatch drops the oldest byte
         if (win[0] != sync_byte || win[1] != type_byte || win[2] != length_code ||
             sum != win[HIST_BYTES]) begin
            win  = win >> 8;
            held = HIST_BYTES;
            return;
         end
         r.wheel_count_left   = le32(POS_COUNT_LEFT);
         r.wheel_count_right  = le32(POS_COUNT_RIGHT);
         r.wheel_period_left  = le16(POS_PERIOD_LEFT);
         r.wheel_period_right = le16(POS_PERIOD_RIGHT);
         r.ranges_low  = {le16(POS_RANGES_LOW + 4), le16(POS_RANGES_LOW + 2),
                          le16(POS_RANGES_LOW)};
         r.ranges_high = {le16(POS_RANGES_HIGH + 4), le16(POS_RANGES_HIGH + 2),
                          le16(POS_RANGES_HIGH)};
         r.battery_voltage = le16(POS_VOLTAGE);
         r.battery_charge  = le16(POS_CHARGE);
         r.heading_angle   = le16(POS_ANGLE);
         // deltas move only once some previous count is nonzero
         if (prev_left != 0 || prev_right != 0) begin
            delta_left  = r.wheel_count_left - prev_left;
            delta_right = prev_right - r.wheel_count_right;
            delta_updates++;
         end
         prev_left  = r.wheel_count_left;
         prev_right = r.wheel_count_right;
         r.wheel_delta_left  = delta_left;
         r.wheel_delta_right = delta_right;
         decoded_q.push_back(r);
         held = 0;
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         mismatches++;
         if (mismatches <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      endtask

      task compare_field(string what, logic [63:0] got, logic [63:0] want);
         if (got !== want) report_mismatch(what, got, want);
      endtask

      // compare one result beat with the oldest decoded frame
      task check_frame(result_type got);
         result_type want;
         if (decoded_q.size() == 0) begin
            report_mismatch("result with no frame pending", got.wheel_count_left, '0);
            return;
         end
         want = decoded_q.pop_front();
         frames_seen++;
         compare_field("wheel_count_left", got.wheel_count_left, want.wheel_count_left);
         compare_field("wheel_count_right", got.wheel_count_right, want.wheel_count_right);
         compare_field("wheel_period_left", got.wheel_period_left, want.wheel_period_left);
         compare_field("wheel_period_right", got.wheel_period_right, want.wheel_period_right);
         compare_field("ranges_low", got.ranges_low, want.ranges_low);
         compare_field("ranges_high", got.ranges_high, want.ranges_high);
         compare_field("battery_voltage", got.battery_voltage, want.battery_voltage);
         compare_field("battery_charge", got.battery_charge, want.battery_charge);
         compare_field("heading_angle", got.heading_angle, want.heading_angle);
         compare_field("wheel_delta_left", got.wheel_delta_left, want.wheel_delta_left);
         compare_field("wheel_delta_right", got.wheel_delta_right, want.wheel_delta_right);
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;

   s8fr_req_if req_bus ();
   s8fr_rsp_if rsp_bus ();

   frame_tracker board;
   result_type   rsp_beat;
   int           bytes_in = 0;
   int           frames_out = 0;
   int           bytes_sent = 0;
   int           settings_used = 0;
   int           quiet_cycles = 0;
   bit           hold_req = 1'b0;
   bit           tx_burst = 1'b0;
   bit           tx_idle_on = 1'b1;
   bit           rx_idle_on = 1'b1;

   sum8_checked_frame_receiver u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // clock
   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // beat monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_beat = {rsp_bus.wheel_count_left, rsp_bus.wheel_count_right,
                        rsp_bus.wheel_period_left, rsp_bus.wheel_period_right,
                        rsp_bus.ranges_low, rsp_bus.ranges_high,
                        rsp_bus.battery_voltage, rsp_bus.battery_charge,
                        rsp_bus.heading_angle, rsp_bus.wheel_delta_left,
                        rsp_bus.wheel_delta_right};
            board.check_frame(rsp_beat);
            frames_out++;
         end
         if (req_bus.valid && req_bus.ready) begin
            board.take_byte(req_bus.rx_byte);
            bytes_in++;
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      int seen;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 79) == 0) rx_idle_on = !rx_idle_on;
         stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         seen = frames_out;
         @(negedge clock);
         while (frames_out == seen && !hold_req) @(negedge clock);
         if (hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
      end
   end

   function automatic frame_bytes_type seal(frame_bytes_type f);
      logic [7:0] sum;
      int         i;
      sum = '0;
      for (i = 0; i < HIST_BYTES; i++) sum += f[i];
      f[HIST_BYTES] = sum;
      return f;
   endfunction

   // well-formed frame for the current header setting
   function automatic frame_bytes_type build_frame(logic [31:0] left, logic [31:0] right,
                                                   fill_type fill);
      frame_bytes_type f;
      int              i;
      for (i = 0; i < FRAME_BYTES; i++) begin
         case (fill)
            FILL_ZERO: f[i] = 8'h00;
            FILL_ONES: f[i] = 8'hFF;
            default:   f[i] = 8'($urandom_range(0, 255));
         endcase
      end
      f[0] = board.sync_byte;
      f[1] = board.type_byte;
      f[2] = board.length_code;
      f[POS_COUNT_LEFT +: 4]  = left;
      f[POS_COUNT_RIGHT +: 4] = right;
      return seal(f);
   endfunction

   function automatic logic [31:0] pick_count();
      case ($urandom_range(0, 15))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic fill_type pick_fill();
      case ($urandom_range(0, 9))
         0:       return FILL_ZERO;
         1:       return FILL_ONES;
         default: return FILL_RANDOM;
      endcase
   endfunction

   // one byte beat; valid stays high for a following byte with no gap
   task automatic send_byte(logic [7:0] b);
      int gap;
      int seen;
      if ($urandom_range(0, 79) == 0) tx_idle_on = !tx_idle_on;
      gap = (tx_idle_on && !tx_burst) ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      seen = bytes_in;
      @(negedge clock);
      while (bytes_in == seen) @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(frame_bytes_type f, int count = FRAME_BYTES);
      int i;
      for (i = 0; i < count; i++) send_byte(f[i]);
   endtask

   // sender pauses until every decoded frame has come out
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.decoded_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      board.set_reg(index, value);
      @(negedge clock);
   endtask

   task automatic apply_setting(logic [7:0] sync_val, logic [7:0] type_val,
                                logic [7:0] length_val);
      write_reg(CSR_SYNC_BYTE, sync_val);
      write_reg(CSR_UNUSED, 8'($urandom_range(0, 255)));
      write_reg(CSR_TYPE_BYTE, type_val);
      write_reg(CSR_LENGTH_CODE, length_val);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // mostly good frames with random content, the rest broken frames and noise
   task automatic random_traffic(int nbytes);
      frame_bytes_type f;
      int              stop;
      int              pick;
      stop = bytes_sent + nbytes;
      while (bytes_sent < stop) begin
         pick = $urandom_range(0, 99);
         f = build_frame(pick_count(), pick_count(), pick_fill());
         if (pick < 60) begin
            send_frame(f);
         end else if (pick < 65) begin
            send_frame(build_frame('0, '0, FILL_RANDOM));
         end else if (pick < 73) begin
            f[HIST_BYTES] ^= 8'($urandom_range(1, 255));
            send_frame(f);
         end else if (pick < 82) begin
            f[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
            send_frame(seal(f));
         end else if (pick < 91) begin
            send_frame(f, $urandom_range(1, HIST_BYTES));
         end else begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      frame_bytes_type f;
      int              k;
      board = new();
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_SYNC_BYTE;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first frame after reset: deltas stay at zero
      send_frame(build_frame(32'd5, 32'd7, FILL_RANDOM));
      // all-ones payload: deltas wrap
      send_frame(build_frame('1, '1, FILL_ONES));
      // each header byte wrong on its own, sum still good
      for (k = 0; k < 3; k++) begin
         f = build_frame(pick_count(), pick_count(), FILL_RANDOM);
         f[k] ^= 8'($urandom_range(1, 255));
         send_frame(seal(f));
      end
      // bad sum byte
      f = build_frame(32'd9, 32'd9, FILL_RANDOM);
      f[HIST_BYTES] ^= 8'($urandom_range(1, 255));
      send_frame(f);
      // zero counts after nonzero ones, then a frame after zero previous counts, whose deltas do not move
      send_frame(build_frame('0, '0, FILL_ZERO));
      send_frame(build_frame(32'd1, 32'd2, FILL_RANDOM));

      random_traffic(PHASE_BYTES);
      drain();

      apply_setting(8'h00, 8'h00, 8'h00);
      random_traffic(PHASE_BYTES);
      drain();

      apply_setting(8'hFF, 8'hFF, 8'hFF);
      random_traffic(PHASE_BYTES);
      drain();

      apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      random_traffic(PHASE_BYTES);
      drain();

      // back to reset values; result side held off while frames go in back to back
      apply_setting(SYNC_BYTE_RESET, TYPE_BYTE_RESET, LENGTH_CODE_RESET);
      hold_req = 1'b1;
      tx_burst = 1'b1;
      repeat (BURST_FRAMES) send_frame(build_frame(pick_count(), pick_count(), FILL_RANDOM));
      tx_burst = 1'b0;
      random_traffic(PHASE_BYTES);
      drain();

      if (board.decoded_q.size() != 0)
         board.report_mismatch("frames never delivered", board.decoded_q.size(), '0);
      $display("covered %0d link bytes, %0d decoded frames (%0d with a delta update)",
               bytes_sent, board.frames_seen, board.delta_updates);
      $display("across %0d header settings plus the reset setting, %0d mismatches",
               settings_used, board.mismatches);
      if (board.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
